// ===== design/grtl_pkg.sv =====
// shared types, widths and codes for the glyph range table lookup block
package grtl_pkg;

	// default store depths
	localparam int MAX_RANGES_DEF = 32;
	localparam int MAX_GLYPHS_DEF = 65536;

	// field widths
	localparam int CP_W    = 21;
	localparam int IDX_W   = 16;
	localparam int SLOT_W  = 16;
	localparam int WID_W   = 8;
	localparam int OFF_W   = 23;
	localparam int RC_W    = 6;
	localparam int GC_W    = 17;
	localparam int BPG_W   = 8;
	localparam int SLOTX_W = 22;
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;

	localparam logic [BPG_W-1:0] BPG_RST = 8'd32;

	typedef enum logic [1:0] {
		OP_WR_RANGE = 2'd0,
		OP_WR_WIDTH = 2'd1,
		OP_LOOKUP   = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		RSN_HIT       = 3'd0,
		RSN_NOT_READY = 3'd1,
		RSN_NO_RANGE  = 3'd2,
		RSN_BEYOND    = 3'd3,
		RSN_EMPTY     = 3'd4
	} reason_t;

	typedef enum logic [1:0] {
		REG_FONT_READY  = 2'd0,
		REG_RANGE_COUNT = 2'd1,
		REG_GLYPH_COUNT = 2'd2,
		REG_BPG         = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic              font_ready;
		logic [RC_W-1:0]   range_count;
		logic [GC_W-1:0]   glyph_count;
		logic [BPG_W-1:0]  bytes_per_glyph;
	} cfg_t;

	typedef struct packed {
		logic    accept;
		logic    search;
		logic    check;
		logic    wchk;
		logic    load_out;
		reason_t reason;
	} cmd_t;

	typedef struct packed {
		logic is_lookup;
		logic font_ready;
		logic hi0_zero;
		logic probe_hit;
		logic probe_go_on;
		logic slot_bad;
		logic w_zero;
		logic out_free;
	} sts_t;

endpackage

// ===== design/grtl_ram.sv =====
// generic single write port ram with registered read
module grtl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/grtl_regs.sv =====
// apb configuration registers
module grtl_regs
	import grtl_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t     cfg_q;
	reg_idx_t sel;
	logic     wr;

	assign sel    = reg_idx_t'(paddr[3:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.font_ready      <= 1'b0;
			cfg_q.range_count     <= '0;
			cfg_q.glyph_count     <= '0;
			cfg_q.bytes_per_glyph <= BPG_RST;
		end else if (wr) begin
			case (sel)
				REG_FONT_READY:  cfg_q.font_ready      <= pwdata[0];
				REG_RANGE_COUNT: cfg_q.range_count     <= pwdata[RC_W-1:0];
				REG_GLYPH_COUNT: cfg_q.glyph_count     <= pwdata[GC_W-1:0];
				REG_BPG:         cfg_q.bytes_per_glyph <= pwdata[BPG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// read mux
	always_comb begin
		case (sel)
			REG_FONT_READY:  prdata = PDATA_W'(cfg_q.font_ready);
			REG_RANGE_COUNT: prdata = PDATA_W'(cfg_q.range_count);
			REG_GLYPH_COUNT: prdata = PDATA_W'(cfg_q.glyph_count);
			REG_BPG:         prdata = PDATA_W'(cfg_q.bytes_per_glyph);
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== design/grtl_ctrl.sv =====
// lookup sequencer state machine
module grtl_ctrl
	import grtl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_CHECK,
		S_WCHK,
		S_DONE
	} state_t;

	state_t  state_q;
	reason_t reason_q;
	logic    accept;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;

	// state and registered miss reason
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			reason_q <= RSN_HIT;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && sts.is_lookup) begin
						if (!sts.font_ready) begin
							reason_q <= RSN_NOT_READY;
							state_q  <= S_DONE;
						end else if (sts.hi0_zero) begin
							reason_q <= RSN_NO_RANGE;
							state_q  <= S_DONE;
						end else begin
							state_q <= S_SEARCH;
						end
					end
				end
				S_SEARCH: begin
					if (sts.probe_hit) begin
						state_q <= S_CHECK;
					end else if (!sts.probe_go_on) begin
						reason_q <= RSN_NO_RANGE;
						state_q  <= S_DONE;
					end
				end
				S_CHECK: begin
					if (sts.slot_bad) begin
						reason_q <= RSN_BEYOND;
						state_q  <= S_DONE;
					end else begin
						state_q <= S_WCHK;
					end
				end
				S_WCHK: begin
					reason_q <= sts.w_zero ? RSN_EMPTY : RSN_HIT;
					state_q  <= S_DONE;
				end
				S_DONE: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath commands
	always_comb begin
		cmd.accept   = accept;
		cmd.search   = (state_q == S_SEARCH);
		cmd.check    = (state_q == S_CHECK);
		cmd.wchk     = (state_q == S_WCHK);
		cmd.load_out = (state_q == S_DONE) && sts.out_free;
		cmd.reason   = reason_q;
	end

`ifndef SYNTHESIS
	a_lookup_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sts.is_lookup) |=> (state_q != S_IDLE))
		else $error("lookup accepted but sequencer stayed idle");
	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && sts.out_free) |=> (state_q == S_IDLE))
		else $error("result loaded but sequencer did not return to idle");
	a_search_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> !cmd.accept && !cmd.load_out)
		else $error("transaction taken during search");
`endif

endmodule

// ===== design/grtl_dp.sv =====
// lookup datapath: range table, width store, search registers, result register
module grtl_dp
	import grtl_pkg::*;
#(
	parameter int MAX_RANGES = MAX_RANGES_DEF,
	parameter int MAX_GLYPHS = MAX_GLYPHS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [1:0]         opcode,
	input  logic [IDX_W-1:0]   entry_index,
	input  logic [CP_W-1:0]    range_first,
	input  logic [CP_W-1:0]    range_last,
	input  logic [SLOT_W-1:0]  range_base,
	input  logic [WID_W-1:0]   width_value,
	input  logic [CP_W-1:0]    code_point,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [2:0]         miss_reason,
	output logic [SLOT_W-1:0]  glyph_slot,
	output logic [WID_W-1:0]   glyph_width,
	output logic [OFF_W-1:0]   bitmap_offset
);

	localparam int RIDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CNT_W  = $clog2(MAX_RANGES + 1);
	localparam int CW     = (CNT_W > RC_W) ? CNT_W : RC_W;
	localparam int GIDX_W = (MAX_GLYPHS > 1) ? $clog2(MAX_GLYPHS) : 1;
	localparam int RENT_W = 2 * CP_W + SLOT_W;

	logic [CP_W-1:0]        cp_q;
	logic [CNT_W-1:0]       lo_q, hi_q, mid_q;
	logic [SLOTX_W-1:0]     slot_q;
	logic [OFF_W-1:0]       offset_q;
	logic [WID_W-1:0]       w_q;

	logic [CW-1:0]          rc_ext;
	logic [CNT_W-1:0]       hi0, mid0;
	logic [CNT_W-1:0]       new_lo, new_hi, mid_nx;
	logic                   is_lookup;

	logic                   rram_we, rram_re;
	logic [RIDX_W-1:0]      rram_raddr;
	logic [RENT_W-1:0]      rram_rdata;
	logic [CP_W-1:0]        ent_first, ent_last;
	logic [SLOT_W-1:0]      ent_base;
	logic                   below, above, probe_hit, go_on;
	logic [CP_W-1:0]        cp_diff;
	logic [SLOTX_W-1:0]     slot_sum;

	logic [SLOTX_W-1:0]     idx_ext;
	logic                   wram_we, wram_re;
	logic [WID_W-1:0]       wram_rdata;
	logic                   slot_bad;
	logic [GC_W+BPG_W-1:0]  prod;

	logic                   out_valid_q;
	logic                   hit_now;

	// search bounds from the clamped range count
	assign rc_ext    = CW'(cfg.range_count);
	assign hi0       = (rc_ext > CW'(MAX_RANGES)) ? CNT_W'(MAX_RANGES) : rc_ext[CNT_W-1:0];
	assign mid0      = hi0 >> 1;
	assign is_lookup = (opcode == OP_LOOKUP);

	// probe compare on the entry read last cycle
	assign ent_first = rram_rdata[RENT_W-1 -: CP_W];
	assign ent_last  = rram_rdata[SLOT_W +: CP_W];
	assign ent_base  = rram_rdata[SLOT_W-1:0];
	assign below     = cp_q < ent_first;
	assign above     = cp_q > ent_last;
	assign probe_hit = !below && !above;
	assign cp_diff   = cp_q - ent_first;
	assign slot_sum  = SLOTX_W'(ent_base) + SLOTX_W'(cp_diff);

	// next interval and midpoint, below the first point wins over past the last
	assign new_lo = (above && !below) ? (mid_q + CNT_W'(1)) : lo_q;
	assign new_hi = below ? mid_q : hi_q;
	assign go_on  = new_lo < new_hi;
	assign mid_nx = new_lo + ((new_hi - new_lo) >> 1);

	// range table
	assign rram_we    = cmd.accept && (opcode == OP_WR_RANGE) &&
	                    (entry_index < IDX_W'(MAX_RANGES));
	assign rram_re    = (cmd.accept && is_lookup && cfg.font_ready && (hi0 != '0)) ||
	                    (cmd.search && !probe_hit && go_on);
	assign rram_raddr = cmd.accept ? mid0[RIDX_W-1:0] : mid_nx[RIDX_W-1:0];

	grtl_ram #(
		.WIDTH (RENT_W),
		.DEPTH (MAX_RANGES)
	) u_range_ram (
		.clk   (clk),
		.we    (rram_we),
		.waddr (entry_index[RIDX_W-1:0]),
		.wdata ({range_first, range_last, range_base}),
		.re    (rram_re),
		.raddr (rram_raddr),
		.rdata (rram_rdata)
	);

	// width store
	assign idx_ext  = SLOTX_W'(entry_index);
	assign wram_we  = cmd.accept && (opcode == OP_WR_WIDTH) &&
	                  (idx_ext < SLOTX_W'(MAX_GLYPHS));
	assign slot_bad = (slot_q >= SLOTX_W'(cfg.glyph_count)) ||
	                  (slot_q >= SLOTX_W'(MAX_GLYPHS));
	assign wram_re  = cmd.check && !slot_bad;

	grtl_ram #(
		.WIDTH (WID_W),
		.DEPTH (MAX_GLYPHS)
	) u_width_ram (
		.clk   (clk),
		.we    (wram_we),
		.waddr (idx_ext[GIDX_W-1:0]),
		.wdata (width_value),
		.re    (wram_re),
		.raddr (slot_q[GIDX_W-1:0]),
		.rdata (wram_rdata)
	);

	// bitmap offset, a hit slot is below the 17-bit glyph count
	assign prod = slot_q[GC_W-1:0] * cfg.bytes_per_glyph;

	// search and check registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			cp_q  <= code_point;
			lo_q  <= '0;
			hi_q  <= hi0;
			mid_q <= mid0;
		end else if (cmd.search) begin
			lo_q   <= new_lo;
			hi_q   <= new_hi;
			mid_q  <= mid_nx;
			slot_q <= slot_sum;
		end
		if (cmd.check) begin
			offset_q <= prod[OFF_W-1:0];
		end
		if (cmd.wchk) begin
			w_q <= wram_rdata;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, zeroed on a miss
	assign hit_now = (cmd.reason == RSN_HIT);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			found         <= hit_now;
			miss_reason   <= cmd.reason;
			glyph_slot    <= hit_now ? slot_q[SLOT_W-1:0] : '0;
			glyph_width   <= hit_now ? w_q : '0;
			bitmap_offset <= hit_now ? offset_q : '0;
		end
	end

	assign out_valid = out_valid_q;

	// status to the sequencer
	always_comb begin
		sts.is_lookup   = is_lookup;
		sts.font_ready  = cfg.font_ready;
		sts.hi0_zero    = (hi0 == '0);
		sts.probe_hit   = probe_hit;
		sts.probe_go_on = go_on;
		sts.slot_bad    = slot_bad;
		sts.w_zero      = (wram_rdata == '0);
		sts.out_free    = !out_valid_q || out_ready;
	end

`ifndef SYNTHESIS
	a_hit_has_width: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && found) |-> (glyph_width != '0) && (miss_reason == RSN_HIT))
		else $error("hit reported with empty width or nonzero reason");
	a_miss_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !found) |->
		(glyph_slot == '0) && (glyph_width == '0) && (bitmap_offset == '0))
		else $error("miss result carries nonzero payload");
	a_mid_in_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.search |-> (lo_q <= mid_q) && (mid_q < hi_q))
		else $error("search midpoint outside interval");
`endif

endmodule

// ===== design/glyph_range_table_lookup_core.sv =====
// top level of the glyph range table lookup block
//
// Input channel (in_valid/in_ready) carries one transaction per item:
// opcode 0 loads a range entry, 1 loads a width byte, 2 looks up a
// code point; opcode 3 is dropped. Writes give no result. A lookup
// binary-searches the range table one probe per cycle on the range
// ram read port, then checks the slot, reads the width ram and
// registers slot times bytes_per_glyph. A lookup skips the search and
// check when the font is not ready or no range is live, and holds the
// input until its result is loaded into the result register.
// Output channel (out_valid/out_ready) is a result register: one
// finished result waits there while the next transaction is taken,
// and a stalled receiver holds only the lookup after it.
// Configuration goes through the apb port while the block is idle; the
// user keeps to this, the block itself does not enforce it. Reset
// clears the registers to their defaults and empties the result
// register; table and width stores hold nothing defined until loaded.
module glyph_range_table_lookup_core
	import grtl_pkg::*;
#(
	parameter int MAX_RANGES = MAX_RANGES_DEF,
	parameter int MAX_GLYPHS = MAX_GLYPHS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         opcode,
	input  logic [IDX_W-1:0]   entry_index,
	input  logic [CP_W-1:0]    range_first,
	input  logic [CP_W-1:0]    range_last,
	input  logic [SLOT_W-1:0]  range_base,
	input  logic [WID_W-1:0]   width_value,
	input  logic [CP_W-1:0]    code_point,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [2:0]         miss_reason,
	output logic [SLOT_W-1:0]  glyph_slot,
	output logic [WID_W-1:0]   glyph_width,
	output logic [OFF_W-1:0]   bitmap_offset
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// configuration registers
	grtl_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer
	grtl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	grtl_dp #(
		.MAX_RANGES (MAX_RANGES),
		.MAX_GLYPHS (MAX_GLYPHS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.sts           (sts),
		.opcode        (opcode),
		.entry_index   (entry_index),
		.range_first   (range_first),
		.range_last    (range_last),
		.range_base    (range_base),
		.width_value   (width_value),
		.code_point    (code_point),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.found         (found),
		.miss_reason   (miss_reason),
		.glyph_slot    (glyph_slot),
		.glyph_width   (glyph_width),
		.bitmap_offset (bitmap_offset)
	);

endmodule
